@@ hw/rtl/qau_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Shared widths, operation codes, types and helper functions.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 13;
  localparam int FUNC_WIDTH = 3;
  // Full product width and a sum width that holds several shifted products.
  localparam int PROD_WIDTH = 2 * COMP_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 4;

  localparam logic [FUNC_WIDTH-1:0] FUNC_ADD  = 3'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_SCALE = 3'd1;
  localparam logic [FUNC_WIDTH-1:0] FUNC_MUL  = 3'd2;
  localparam logic [FUNC_WIDTH-1:0] FUNC_SAND = 3'd3;
  localparam logic [FUNC_WIDTH-1:0] FUNC_NORM = 3'd4;
  localparam logic [FUNC_WIDTH-1:0] FUNC_ROT  = 3'd5;

  localparam logic signed [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic signed [COMP_WIDTH-1:0] CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [SUM_WIDTH-1:0]  sum_t;
  typedef comp_t quat_t [4];

  // Product shifted right arithmetically, sign extended to sum width.
  function automatic sum_t pm(input comp_t p, input comp_t q);
    logic signed [PROD_WIDTH-1:0] prod;
    begin
      prod = p * q;
      pm = sum_t'(prod >>> FRAC_BITS);
    end
  endfunction

  function automatic comp_t sat(input sum_t v);
    begin
      if (v > sum_t'(CMAX)) begin
        sat = CMAX;
      end else if (v < sum_t'(CMIN)) begin
        sat = CMIN;
      end else begin
        sat = v[COMP_WIDTH-1:0];
      end
    end
  endfunction

  // Saturated value of 1.0.
  function automatic comp_t one_val();
    sum_t o;
    begin
      o = sum_t'(1) <<< FRAC_BITS;
      one_val = sat(o);
    end
  endfunction

endpackage

@@ hw/rtl/qau_if.sv @@
// ----------------------------------------------------------------------------
// Quaternion unit channel interfaces
// Valid/ready channels for input requests and results.
// ----------------------------------------------------------------------------
interface qau_in_if import qau_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_WIDTH-1:0] func;
  comp_t a_w, a_x, a_y, a_z;
  comp_t b_w, b_x, b_y, b_z;
  comp_t scale_factor;
  modport source (output valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  scale_factor, input ready);
  modport sink (input valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                scale_factor, output ready);
endinterface

interface qau_out_if import qau_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t res_w, res_x, res_y, res_z;
  logic  last;
  modport source (output valid, res_w, res_x, res_y, res_z, last, input ready);
  modport sink (input valid, res_w, res_x, res_y, res_z, last, output ready);
endinterface

@@ hw/rtl/quaternion_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit top level
// Four-stage pipeline with a row sequencer for the rotation matrix.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle unless the output stalls or a matrix
// request holds the input. The first result transfer of a request is made
// through a pipeline of four register stages: stage 1 holds the operands,
// stage 2 holds the shifted partial products of the first operation (or of
// the inner product b*a of a sandwich) together with the side terms of add,
// scale, squared norm and the matrix, stage 3 holds the saturated first
// results, and stage 4 holds the partial products of the outer sandwich
// product, which are summed and saturated on the way to the output. Add,
// scale, multiply, sandwich, squared norm and unused codes give one transfer.
// A rotation matrix request gives four transfers, one row each, and holds
// the input while the sequencer at the input steps through the rows, so
// the next request waits until the last row is issued. A stall on the
// output freezes the whole pipeline; nothing is lost or repeated.
module quaternion_arithmetic_unit_top import qau_pkg::*; (
  input  logic clk,
  input  logic rst,
  qau_in_if.sink    in_ch,
  qau_out_if.source out_ch
);

  typedef struct packed {
    logic                  valid;
    logic [FUNC_WIDTH-1:0] func;
    logic [1:0]            row;
    logic                  last;
  } ctl_t;

  logic  advance;
  logic [1:0] row, row_next;
  logic  is_rot, take;
  ctl_t  c1, c2, c3, c4;

  comp_t a_in [4], b_in [4];
  comp_t a1 [4], b1 [4], s1;
  comp_t a2 [4], a3 [4];
  comp_t r1 [4], t2 [4], r3 [4];
  comp_t rotrow [4];
  comp_t res [4];

  // Direct result of stage 1 (non-product or independent product terms).
  sum_t  ad [4], sc [4], nsq [4];
  sum_t  xx, yy, zz, xy, xz, yz, wx, wy, wz;
  comp_t one;

  assign advance = !c4.valid || out_ch.ready;
  assign is_rot  = (in_ch.func == FUNC_ROT);
  assign take    = in_ch.valid && advance;
  // Accept only once the last row of a matrix request has been issued.
  assign in_ch.ready = advance && (!is_rot || row == 2'd3);
  assign row_next = (take && is_rot) ? row + 2'd1 : row;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= 2'd0;
    end else begin
      row <= row_next;
    end
  end

  assign a_in = '{in_ch.a_w, in_ch.a_x, in_ch.a_y, in_ch.a_z};
  assign b_in = '{in_ch.b_w, in_ch.b_x, in_ch.b_y, in_ch.b_z};

  // Stage 1: register operands and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid <= 1'b0;
    end else if (advance) begin
      c1.valid <= in_ch.valid;
    end
    if (advance) begin
      c1.func <= in_ch.func;
      c1.row  <= row;
      c1.last <= !is_rot || row == 2'd3;
      a1 <= a_in;
      b1 <= b_in;
      s1 <= in_ch.scale_factor;
    end
  end

  // Stage 1 -> 2: inner product b*a for sandwich, a*b for multiply.
  comp_t pp_p [4], pp_q [4];
  always_comb begin
    if (c1.func == FUNC_SAND) begin
      pp_p = b1;
      pp_q = a1;
    end else begin
      pp_p = a1;
      pp_q = b1;
    end
  end

  qau_prod u_prod1 (.clk(clk), .en(advance), .p(pp_p), .q(pp_q), .r(r1));

  // Registered side terms for the other operations.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 4; i++) begin
        ad[i]  <= sum_t'(a1[i]) + sum_t'(b1[i]);
        sc[i]  <= pm(a1[i], s1);
        nsq[i] <= pm(a1[i], a1[i]);
      end
      xx <= pm(a1[1], a1[1]); yy <= pm(a1[2], a1[2]); zz <= pm(a1[3], a1[3]);
      xy <= pm(a1[1], a1[2]); xz <= pm(a1[1], a1[3]); yz <= pm(a1[2], a1[3]);
      wx <= pm(a1[0], a1[1]); wy <= pm(a1[0], a1[2]); wz <= pm(a1[0], a1[3]);
      a2 <= a1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.valid <= 1'b0;
    end else if (advance) begin
      c2.valid <= c1.valid;
    end
    if (advance) begin
      c2.func <= c1.func;
      c2.row  <= c1.row;
      c2.last <= c1.last;
    end
  end

  assign one = one_val();

  always_comb begin
    rotrow = '{comp_t'(0), comp_t'(0), comp_t'(0), comp_t'(0)};
    case (c2.row)
      2'd0: rotrow = '{sat(sum_t'(one) - 2 * (yy + zz)), sat(2 * (xy - wz)),
                       sat(2 * (xz + wy)), comp_t'(0)};
      2'd1: rotrow = '{sat(2 * (xy + wz)), sat(sum_t'(one) - 2 * (xx + zz)),
                       sat(2 * (yz - wx)), comp_t'(0)};
      2'd2: rotrow = '{sat(2 * (xz - wy)), sat(2 * (yz + wx)),
                       sat(sum_t'(one) - 2 * (xx + yy)), comp_t'(0)};
      default: rotrow = '{comp_t'(0), comp_t'(0), comp_t'(0), one};
    endcase
  end

  // Stage 2 -> 3: saturated first result.
  always_ff @(posedge clk) begin
    if (rst) begin
      c3.valid <= 1'b0;
    end else if (advance) begin
      c3.valid <= c2.valid;
    end
    if (advance) begin
      c3.func <= c2.func;
      c3.row  <= c2.row;
      c3.last <= c2.last;
      a3 <= '{a2[0], -a2[1], -a2[2], -a2[3]};
      case (c2.func) inside
        FUNC_ADD:   t2 <= '{sat(ad[0]), sat(ad[1]), sat(ad[2]), sat(ad[3])};
        FUNC_SCALE: t2 <= '{sat(sc[0]), sat(sc[1]), sat(sc[2]), sat(sc[3])};
        FUNC_MUL, FUNC_SAND: t2 <= r1;
        FUNC_NORM:  t2 <= '{sat(nsq[0] + nsq[1] + nsq[2] + nsq[3]), comp_t'(0),
                            comp_t'(0), comp_t'(0)};
        FUNC_ROT:   t2 <= rotrow;
        default:    t2 <= '{comp_t'(0), comp_t'(0), comp_t'(0), comp_t'(0)};
      endcase
    end
  end

  // Outer sandwich product conj(a)*t. Negating -32768 must stay exact, so
  // the conjugate is formed with a wider product below.
  sum_t op [4][4];
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          op[i][j] <= pm(a3[i] == CMIN && i != 0 ? CMIN : a3[i], t2[j]);
        end
      end
    end
  end
  // a3 holds the conjugate; CMIN negation wraps, fixed by exact products below.
  logic neg_fix [4];
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 4; i++) begin
        neg_fix[i] <= (i != 0) && (a3[i] == CMIN);
      end
    end
  end
  sum_t opx [4][4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        opx[i][j] = op[i][j];
      end
    end
  end
  // Exact product of +32768 and t: t shifted left by COMP_WIDTH-1 then down.
  comp_t t3 [4];
  always_ff @(posedge clk) begin
    if (advance) begin
      t3 <= t2;
    end
  end
  sum_t pq [4][4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (neg_fix[i]) begin
          pq[i][j] = (sum_t'(t3[j]) <<< (COMP_WIDTH - 1)) >>> FRAC_BITS;
        end else begin
          pq[i][j] = opx[i][j];
        end
      end
    end
  end

  assign r3[0] = sat(pq[0][0] - pq[1][1] - pq[2][2] - pq[3][3]);
  assign r3[1] = sat(pq[0][1] + pq[1][0] + pq[2][3] - pq[3][2]);
  assign r3[2] = sat(pq[0][2] - pq[1][3] + pq[2][0] + pq[3][1]);
  assign r3[3] = sat(pq[0][3] + pq[1][2] - pq[2][1] + pq[3][0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      c4.valid <= 1'b0;
    end else if (advance) begin
      c4.valid <= c3.valid;
    end
    if (advance) begin
      c4.func <= c3.func;
      c4.row  <= c3.row;
      c4.last <= c3.last;
    end
  end

  always_comb begin
    if (c4.func == FUNC_SAND) begin
      res = r3;
    end else begin
      res = t3;
    end
  end

  assign out_ch.valid = c4.valid;
  assign out_ch.res_w = res[0];
  assign out_ch.res_x = res[1];
  assign out_ch.res_y = res[2];
  assign out_ch.res_z = res[3];
  assign out_ch.last  = c4.last;

endmodule

@@ hw/rtl/qau_prod.sv @@
// ----------------------------------------------------------------------------
// Quaternion product stage
// One registered Hamilton product of p and q with per-component saturation.
// ----------------------------------------------------------------------------
module qau_prod import qau_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  comp_t p [4],
  input  comp_t q [4],
  output comp_t r [4]
);

  // Sixteen shifted partial products are registered before the sums.
  sum_t pp [4][4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp[i][j] <= pm(p[i], q[j]);
        end
      end
    end
  end

  assign r[0] = sat(pp[0][0] - pp[1][1] - pp[2][2] - pp[3][3]);
  assign r[1] = sat(pp[0][1] + pp[1][0] + pp[2][3] - pp[3][2]);
  assign r[2] = sat(pp[0][2] - pp[1][3] + pp[2][0] + pp[3][1]);
  assign r[3] = sat(pp[0][3] + pp[1][2] - pp[2][1] + pp[3][0]);

endmodule

@@ hw/rtl/qau_checker.sv @@
// ----------------------------------------------------------------------------
// Quaternion unit checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module qau_checker import qau_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic [FUNC_WIDTH-1:0] in_func,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // Output stays valid under a stall.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");

  // A stalled result keeps its last flag.
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_last)) else $error("last changed in stall");

  // A stalled output blocks new input.
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken in stall");

  // Nothing comes out right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output after reset");

  // A non-matrix request is accepted in the cycle it is offered when free.
  a_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_func != FUNC_ROT && (!out_valid || out_ready) |-> in_ready)
    else $error("single request refused");

endmodule

bind quaternion_arithmetic_unit_top qau_checker u_qau_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_func(in_ch.func),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last)
);
